// ===== sv/obm_pkg.sv =====
package obm_pkg;

  // Default table size and instrument range
  localparam int unsigned ORDER_SLOTS_DEF  = 32;
  localparam int unsigned INSTRUMENT_COUNT = 16;

  // Operation codes
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_CANCEL = 1'b1;

  // Side codes
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_TRADE  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // One resting order
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] client;
    logic [3:0]  instrument;
    logic        side;
    logic [31:0] quantity;
    logic [31:0] price;
  } slot_t;

endpackage

// ===== sv/obm_if.sv =====
// Order request channel
interface obm_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] client;
  logic [3:0]  instrument;
  logic        side;
  logic [31:0] quantity;
  logic [31:0] price;
  logic [31:0] cancel_id;

  modport source (output valid, func, client, instrument, side, quantity, price, cancel_id,
                  input ready);
  modport sink   (input valid, func, client, instrument, side, quantity, price, cancel_id,
                  output ready);
endinterface

// Result channel
interface obm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] txn_id;
  logic [15:0] buyer_client;
  logic [15:0] seller_client;
  logic [3:0]  trade_instrument;
  logic [31:0] trade_quantity;
  logic [31:0] trade_price;
  logic        rested;
  logic        ok;
  logic        last;

  modport source (output valid, result_kind, txn_id, buyer_client, seller_client,
                  trade_instrument, trade_quantity, trade_price, rested, ok, last,
                  input ready);
  modport sink   (input valid, result_kind, txn_id, buyer_client, seller_client,
                  trade_instrument, trade_quantity, trade_price, rested, ok, last,
                  output ready);
endinterface

// ===== sv/obm_slot_ram.sv =====
module obm_slot_ram #(
  parameter int unsigned DEPTH = obm_pkg::ORDER_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  obm_pkg::slot_t           wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output obm_pkg::slot_t           rdata_o
);
  import obm_pkg::*;

  slot_t mem_q [DEPTH];
  slot_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/order_book_exact_price_matcher.sv =====
// Cancel: its result follows one table scan from acceptance.
// Add with T trades: T + 1 table scans, one scan less when the last trade fills it; zero
// quantity or bad instrument: no scan. Scans read one slot per cycle.
// One transaction at a time: ready again as soon as the final result is registered; a
// result stalled in the output register holds the sequencer until it is taken.
// Reset (async, active low) clears valid bits, sequencer and output valid; next id is 1.
module order_book_exact_price_matcher #(
  parameter int unsigned ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  obm_req_if.sink   req,
  obm_rsp_if.source rsp
);
  import obm_pkg::*;

  localparam int unsigned SLOT_W = $clog2(ORDER_SLOTS);
  localparam int unsigned CNT_W  = $clog2(ORDER_SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ORDER_SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_TRD_RD = 3'd2;
  localparam logic [2:0] S_TRADE  = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_CFIN   = 3'd5;

  logic [2:0] state_q, state_d;

  // Latched transaction
  logic        func_q, func_d;
  logic [15:0] client_q, client_d;
  logic [3:0]  inst_q, inst_d;
  logic        side_q, side_d;
  logic [31:0] qty_q, qty_d;
  logic [31:0] price_q, price_d;
  logic [31:0] cid_q, cid_d;
  logic [31:0] id_q, id_d;
  logic        bad_q, bad_d;
  logic [31:0] next_id_q, next_id_d;

  // Scan state
  logic [CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   pv_q, pv_d;
  logic [SLOT_W-1:0]      pidx_q, pidx_d;
  logic                   best_found_q, best_found_d;
  logic [SLOT_W-1:0]      best_idx_q, best_idx_d;
  logic [31:0]            best_key_q, best_key_d;
  logic                   free_found_q, free_found_d;
  logic [SLOT_W-1:0]      free_idx_q, free_idx_d;
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;
  logic [ORDER_SLOTS-1:0] visited_q, visited_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  o_kind_q, o_kind_d;
  logic [31:0] o_id_q, o_id_d;
  logic [15:0] o_buyer_q, o_buyer_d;
  logic [15:0] o_seller_q, o_seller_d;
  logic [3:0]  o_inst_q, o_inst_d;
  logic [31:0] o_qty_q, o_qty_d;
  logic [31:0] o_price_q, o_price_d;
  logic        o_rested_q, o_rested_d;
  logic        o_ok_q, o_ok_d;
  logic        o_last_q, o_last_d;

  // RAM ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  slot_t             ram_rdata;

  logic        out_free;
  logic        hit;
  logic [31:0] key;
  logic [31:0] trade_qty;
  logic [31:0] qty_left;
  logic [31:0] slot_left;
  logic        fin_rested;
  logic        fin_ok;

  obm_slot_ram #(.DEPTH(ORDER_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req.ready = (state_q == S_IDLE);
  assign out_free  = !out_valid_q || rsp.ready;

  // Read address: scan counter, or the chosen slot while trading
  always_comb begin
    ram_raddr = best_idx_q;
    if (state_q == S_SCAN) begin
      ram_raddr = (rd_idx_q < LAST_CNT) ? rd_idx_q[SLOT_W-1:0] : '0;
    end
  end

  // Shared compare unit on the slot that just came out of the RAM
  assign key = ram_rdata.id - next_id_q;
  assign hit = valid_q[pidx_q] && !visited_q[pidx_q] && (ram_rdata.side != side_q) &&
               (ram_rdata.instrument == inst_q) && (ram_rdata.price == price_q);

  // Trade arithmetic
  assign trade_qty = (qty_q < ram_rdata.quantity) ? qty_q : ram_rdata.quantity;
  assign qty_left  = qty_q - trade_qty;
  assign slot_left = ram_rdata.quantity - trade_qty;

  // Add completion flags
  assign fin_rested = !bad_q && (qty_q != 32'd0) && free_found_q;
  assign fin_ok     = !bad_q && ((qty_q == 32'd0) || free_found_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    client_d     = client_q;
    inst_d       = inst_q;
    side_d       = side_q;
    qty_d        = qty_q;
    price_d      = price_q;
    cid_d        = cid_q;
    id_d         = id_q;
    bad_d        = bad_q;
    next_id_d    = next_id_q;
    rd_idx_d     = rd_idx_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_key_d   = best_key_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    visited_d    = visited_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    o_kind_d     = o_kind_q;
    o_id_d       = o_id_q;
    o_buyer_d    = o_buyer_q;
    o_seller_d   = o_seller_q;
    o_inst_d     = o_inst_q;
    o_qty_d      = o_qty_q;
    o_price_d    = o_price_q;
    o_rested_d   = o_rested_q;
    o_ok_d       = o_ok_q;
    o_last_d     = o_last_q;
    ram_we       = 1'b0;
    ram_waddr    = best_idx_q;
    ram_wdata    = ram_rdata;

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          func_d       = req.func;
          client_d     = req.client;
          inst_d       = req.instrument;
          side_d       = req.side;
          qty_d        = req.quantity;
          price_d      = req.price;
          cid_d        = req.cancel_id;
          rd_idx_d     = '0;
          best_found_d = 1'b0;
          free_found_d = 1'b0;
          visited_d    = '0;
          bad_d        = 1'b0;
          state_d      = S_SCAN;
          if (req.func == FUNC_ADD) begin
            id_d      = next_id_q;
            next_id_d = next_id_q + 32'd1;
            bad_d     = ({5'd0, req.instrument} >= 9'(INSTRUMENT_COUNT));
            if (bad_d || (req.quantity == 32'd0)) begin
              state_d = S_FIN;
            end
          end
        end
      end

      S_SCAN: begin
        // Issue the next read
        if (rd_idx_q < LAST_CNT) begin
          pv_d     = 1'b1;
          pidx_d   = rd_idx_q[SLOT_W-1:0];
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
        // Evaluate the slot returned by the RAM
        if (pv_q) begin
          if (func_q == FUNC_ADD) begin
            if (hit && (!best_found_q || (key < best_key_q))) begin
              best_found_d = 1'b1;
              best_idx_d   = pidx_q;
              best_key_d   = key;
            end
            if (!valid_q[pidx_q] && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = pidx_q;
            end
          end else if (valid_q[pidx_q] && (ram_rdata.id == cid_q) && !best_found_q) begin
            best_found_d = 1'b1;
            best_idx_d   = pidx_q;
          end
        end
        // Pass complete
        if ((rd_idx_q == LAST_CNT) && !pv_q) begin
          if (func_q == FUNC_CANCEL) begin
            state_d = S_CFIN;
          end else if (best_found_q) begin
            state_d = S_TRD_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_TRD_RD: begin
        state_d = S_TRADE;
      end

      S_TRADE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = KIND_TRADE;
          o_id_d      = id_q;
          o_buyer_d   = (side_q == SIDE_BUY) ? client_q : ram_rdata.client;
          o_seller_d  = (side_q == SIDE_BUY) ? ram_rdata.client : client_q;
          o_inst_d    = inst_q;
          o_qty_d     = trade_qty;
          o_price_d   = price_q;
          o_rested_d  = 1'b0;
          o_ok_d      = 1'b0;
          o_last_d    = 1'b0;
          // Write back the reduced resting quantity
          ram_we             = 1'b1;
          ram_waddr          = best_idx_q;
          ram_wdata.quantity = slot_left;
          if (slot_left == 32'd0) begin
            valid_d[best_idx_q] = 1'b0;
          end
          visited_d[best_idx_q] = 1'b1;
          qty_d                 = qty_left;
          rd_idx_d              = '0;
          best_found_d          = 1'b0;
          free_found_d          = 1'b0;
          state_d               = (qty_left == 32'd0) ? S_FIN : S_SCAN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = KIND_ADD;
          o_id_d      = id_q;
          o_buyer_d   = '0;
          o_seller_d  = '0;
          o_inst_d    = '0;
          o_qty_d     = '0;
          o_price_d   = '0;
          o_rested_d  = fin_rested;
          o_ok_d      = fin_ok;
          o_last_d    = 1'b1;
          // Rest the remainder in the lowest free slot
          if (fin_rested) begin
            ram_we               = 1'b1;
            ram_waddr            = free_idx_q;
            ram_wdata.id         = id_q;
            ram_wdata.client     = client_q;
            ram_wdata.instrument = inst_q;
            ram_wdata.side       = side_q;
            ram_wdata.quantity   = qty_q;
            ram_wdata.price      = price_q;
            valid_d[free_idx_q]  = 1'b1;
          end
          state_d = S_IDLE;
        end
      end

      S_CFIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = KIND_CANCEL;
          o_id_d      = cid_q;
          o_buyer_d   = '0;
          o_seller_d  = '0;
          o_inst_d    = '0;
          o_qty_d     = '0;
          o_price_d   = '0;
          o_rested_d  = 1'b0;
          o_ok_d      = best_found_q;
          o_last_d    = 1'b1;
          if (best_found_q) begin
            valid_d[best_idx_q] = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      next_id_q   <= 32'd1;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
      pv_q        <= pv_d;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    client_q     <= client_d;
    inst_q       <= inst_d;
    side_q       <= side_d;
    qty_q        <= qty_d;
    price_q      <= price_d;
    cid_q        <= cid_d;
    id_q         <= id_d;
    bad_q        <= bad_d;
    rd_idx_q     <= rd_idx_d;
    pidx_q       <= pidx_d;
    best_found_q <= best_found_d;
    best_idx_q   <= best_idx_d;
    best_key_q   <= best_key_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    visited_q    <= visited_d;
    o_kind_q     <= o_kind_d;
    o_id_q       <= o_id_d;
    o_buyer_q    <= o_buyer_d;
    o_seller_q   <= o_seller_d;
    o_inst_q     <= o_inst_d;
    o_qty_q      <= o_qty_d;
    o_price_q    <= o_price_d;
    o_rested_q   <= o_rested_d;
    o_ok_q       <= o_ok_d;
    o_last_q     <= o_last_d;
  end

  assign rsp.valid            = out_valid_q;
  assign rsp.result_kind      = o_kind_q;
  assign rsp.txn_id           = o_id_q;
  assign rsp.buyer_client     = o_buyer_q;
  assign rsp.seller_client    = o_seller_q;
  assign rsp.trade_instrument = o_inst_q;
  assign rsp.trade_quantity   = o_qty_q;
  assign rsp.trade_price      = o_price_q;
  assign rsp.rested           = o_rested_q;
  assign rsp.ok               = o_ok_q;
  assign rsp.last             = o_last_q;

endmodule

// ===== sv/obm_checker.sv =====
module obm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_kind_i,
  input logic [31:0] rsp_id_i,
  input logic [31:0] rsp_qty_i,
  input logic        rsp_rested_i,
  input logic        rsp_ok_i,
  input logic        rsp_last_i
);
  import obm_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_id_i) && $stable(rsp_kind_i))
    else $error("result changed while stalled");

  // Trades are never last; completions always are
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_last_i == (rsp_kind_i != KIND_TRADE)))
    else $error("last flag disagrees with result kind");

  // A trade moves a nonzero quantity and carries no status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_kind_i == KIND_TRADE) |->
      (rsp_qty_i != 32'd0) && !rsp_ok_i && !rsp_rested_i)
    else $error("malformed trade");

  // Resting implies success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_rested_i |-> rsp_ok_i && (rsp_kind_i == KIND_ADD))
    else $error("rested without ok");

  // One transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

endmodule

bind order_book_exact_price_matcher obm_checker u_obm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_kind_i   (rsp.result_kind),
  .rsp_id_i     (rsp.txn_id),
  .rsp_qty_i    (rsp.trade_quantity),
  .rsp_rested_i (rsp.rested),
  .rsp_ok_i     (rsp.ok),
  .rsp_last_i   (rsp.last)
);
